/* rtl/core/brms_pkg.sv */
package brms_pkg;

  localparam int unsigned SampleW       = 16;
  localparam int unsigned LevelW        = 24;
  localparam int unsigned CntW          = 11;
  localparam int unsigned SumW          = 41;
  localparam int unsigned FracW         = 16;
  localparam int unsigned DefMaxSamples = 1024;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  // shared divider / root shift register, one spare top bit keeps it even
  localparam int unsigned WorkW     = SumW + FracW + 1;
  localparam int unsigned DivSteps  = WorkW;
  localparam int unsigned SqrtSteps = WorkW / 2;
  localparam int unsigned RootW     = SqrtSteps;
  localparam int unsigned RemW      = RootW + 3;
  localparam int unsigned StepW     = $clog2(DivSteps);

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0] rms_level;
    logic [CntW-1:0]   samples_in_block;
    logic              overflowed;
  } out_item_t;

  typedef struct packed {
    logic acc_en;
    logic div_load;
    logic div_step;
    logic sqrt_step;
    logic out_load;
  } cmd_t;

endpackage

/* rtl/core/brms_datapath.sv */
module brms_datapath
  import brms_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = DefMaxSamples
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  cmd_t      cmd_i,
  output out_item_t out_item_o
);

  localparam int unsigned TallyW = $clog2(MAX_SAMPLES + 1);

  logic [SumW-1:0]   sum_q, sum_d;
  logic [TallyW-1:0] tally_q, tally_d;
  logic              ovf_q, ovf_d;

  logic signed [2*SampleW-1:0] product;
  logic [SumW:0]               sum_wide;
  logic [SumW-1:0]             sum_sat;

  logic [WorkW-1:0]  work_q;
  logic [TallyW-1:0] divisor_q;
  logic [TallyW-1:0] rem_q;
  logic              ovf_snap_q;
  logic [RootW-1:0]  root_q;
  logic [RemW-1:0]   sq_rem_q;

  logic [TallyW:0]   div_shift, div_diff;
  logic              div_ge;
  logic [TallyW-1:0] div_rem_next;

  logic [RemW-1:0]   sq_shift, sq_trial;
  logic              sq_ge;

  out_item_t out_q;

  assign product  = in_item_i.sample * in_item_i.sample;
  assign sum_wide = {1'b0, sum_q} + (SumW + 1)'($unsigned(product));
  assign sum_sat  = sum_wide[SumW] ? SumMax : sum_wide[SumW-1:0];

  always_comb begin
    sum_d   = sum_q;
    tally_d = tally_q;
    ovf_d   = ovf_q;
    if (tally_q >= TallyW'(MAX_SAMPLES)) begin
      ovf_d = 1'b1;
    end else begin
      tally_d = tally_q + 1'b1;
      sum_d   = sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      tally_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.acc_en) begin
      if (cmd_i.div_load) begin
        sum_q   <= '0;
        tally_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        sum_q   <= sum_d;
        tally_q <= tally_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  assign div_shift    = {rem_q, work_q[WorkW-1]};
  assign div_diff     = div_shift - {1'b0, divisor_q};
  assign div_ge       = div_shift >= {1'b0, divisor_q};
  assign div_rem_next = div_ge ? div_diff[TallyW-1:0] : div_shift[TallyW-1:0];

  assign sq_shift = {sq_rem_q[RemW-3:0], work_q[WorkW-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_shift >= sq_trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      work_q     <= {{(WorkW - SumW - FracW){1'b0}}, sum_d, {FracW{1'b0}}};
      divisor_q  <= tally_d;
      ovf_snap_q <= ovf_d;
      rem_q      <= '0;
      root_q     <= '0;
      sq_rem_q   <= '0;
    end else if (cmd_i.div_step) begin
      work_q <= {work_q[WorkW-2:0], div_ge};
      rem_q  <= div_rem_next;
    end else if (cmd_i.sqrt_step) begin
      work_q   <= {work_q[WorkW-3:0], 2'b00};
      sq_rem_q <= sq_ge ? (sq_shift - sq_trial) : sq_shift;
      root_q   <= {root_q[RootW-2:0], sq_ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.rms_level        <= (divisor_q == '0) ? '0 : root_q[LevelW-1:0];
      out_q.samples_in_block <= CntW'(divisor_q);
      out_q.overflowed       <= ovf_snap_q;
    end
  end

  assign out_item_o = out_q;

endmodule

/* rtl/core/brms_ctrl.sv */
module brms_ctrl
  import brms_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  input  logic out_stall_i,
  output logic in_stall_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StAcc,
    StDiv,
    StSqrt,
    StDone
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] step_q;
  logic             out_valid_q;

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      StAcc: begin
        in_stall_o      = 1'b0;
        cmd_o.acc_en    = in_valid_i;
        cmd_o.div_load  = in_valid_i && in_last_i;
      end
      StDiv:  cmd_o.div_step  = 1'b1;
      StSqrt: cmd_o.sqrt_step = 1'b1;
      StDone: cmd_o.out_load  = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StAcc;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !cmd_o.out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StAcc: begin
          if (cmd_o.div_load) begin
            state_q <= StDiv;
            step_q  <= '0;
          end
        end
        StDiv: begin
          if (step_q == StepW'(DivSteps - 1)) begin
            state_q <= StSqrt;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        StSqrt: begin
          if (step_q == StepW'(SqrtSteps - 1)) begin
            state_q <= StDone;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        StDone: begin
          if (cmd_o.out_load) begin
            out_valid_q <= 1'b1;
            state_q     <= StAcc;
          end
        end
        default: state_q <= StAcc;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_last_i) |=> in_stall_o)
    else $error("input not held after block end");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(out_valid_q && out_stall_i))
    else $error("waiting result overwritten");

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.div_step && cmd_o.sqrt_step))
    else $error("divider and root stepped together");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StDone))
    else $error("result raised outside completion");
`endif

endmodule

/* rtl/core/block_rms_level_meter.sv */
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o   | in_item_i  (sample, last)
// out     | output    | out_valid_o/out_stall_i | out_item_o (rms_level, samples_in_block,
//         |           |                         |             overflowed)
// Samples without last stream back to back.
// A sample with last holds the input stalled through 58 steps of the
// one-bit-per-cycle restoring divider, 29 steps of the two-bit root unit and one load.
// The result waits in an output register; a stalled output delays the load only.
// Reset is asynchronous, active low, and clears the sums, count and control.
module block_rms_level_meter
  import brms_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = DefMaxSamples
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  cmd_t cmd;

  brms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_item_i.last),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  brms_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .out_item_o (out_item_o)
  );

endmodule
